FILE: hw/rtl/lsw_pkg.sv
`timescale 1ns / 1ps

package lsw_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_PARAM = 2'd1,
    KIND_PIXEL = 2'd2
  } kind_e;

  // widths of the packed stream
  localparam int unsigned StreamW = 40;
  localparam int unsigned PendW   = 7;
  localparam int unsigned WordW   = 9;

  // bit counts appended by each kind
  localparam logic [5:0] BitsOneWord   = 6'd9;
  localparam logic [5:0] BitsThreeWord = 6'd27;

  // one packed item handed from the packer to the byte emitter
  typedef struct packed {
    logic [StreamW-1:0] stream;  // left aligned, first bit at the top
    logic [2:0]         nbytes;  // bytes to send, 0 to 5
    logic               last;    // item closes the transfer
  } pack_t;

endpackage

FILE: hw/rtl/lsw_item_if.sv
`timescale 1ns / 1ps

interface lsw_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_item;

  modport source (
    output valid, kind, data_byte, red, green, blue, last_item,
    input  ready
  );

  modport sink (
    input  valid, kind, data_byte, red, green, blue, last_item,
    output ready
  );
endinterface

FILE: hw/rtl/lsw_byte_if.sv
`timescale 1ns / 1ps

interface lsw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       transfer_end;

  modport source (
    output valid, out_byte, run_end, transfer_end,
    input  ready
  );

  modport sink (
    input  valid, out_byte, run_end, transfer_end,
    output ready
  );
endinterface

FILE: hw/rtl/lsw_pack.sv
`timescale 1ns / 1ps

module lsw_pack (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  lsw_item_if.sink      in_i,
  output logic          pack_valid_o,
  input  logic          pack_ready_i,
  output lsw_pkg::pack_t pack_o
);

  logic       in_valid_q;
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic [7:0] red_q;
  logic [7:0] green_q;
  logic [7:0] blue_q;
  logic       last_q;
  logic       fmt_q;

  logic [lsw_pkg::PendW-1:0] pend_q, pend_d;
  logic [2:0]                pcnt_q, pcnt_d;

  logic       in_ready;
  logic       pop;

  logic [7:0]                  comp_r, comp_g, comp_b;
  logic [26:0]                 words;
  logic [5:0]                  wbits;
  logic [5:0]                  total;
  logic [2:0]                  nfull;
  logic [2:0]                  rem;
  logic                        pad;
  logic [lsw_pkg::StreamW-1:0] stream;
  logic [lsw_pkg::StreamW-1:0] rest;

  assign pop      = in_valid_q & pack_ready_i;
  assign in_ready = ~in_valid_q | pack_ready_i;
  assign in_i.ready = in_ready;

  // colour format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      kind_q  <= in_i.kind;
      data_q  <= in_i.data_byte;
      red_q   <= in_i.red;
      green_q <= in_i.green;
      blue_q  <= in_i.blue;
      last_q  <= in_i.last_item;
    end
  end

  // pixel components, rgb565 values moved up to the top of the byte
  always_comb begin
    if (fmt_q) begin
      comp_r = red_q;
      comp_g = green_q;
      comp_b = blue_q;
    end else begin
      comp_r = {red_q[4:0], 3'b000};
      comp_g = {green_q[5:0], 2'b00};
      comp_b = {blue_q[4:0], 3'b000};
    end
  end

  // 9-bit words of the item, first word at the top
  always_comb begin
    case (kind_q)
      lsw_pkg::KIND_CMD: begin
        words = {1'b0, data_q, 18'd0};
        wbits = lsw_pkg::BitsOneWord;
      end
      lsw_pkg::KIND_PARAM: begin
        words = {1'b1, data_q, 18'd0};
        wbits = lsw_pkg::BitsOneWord;
      end
      lsw_pkg::KIND_PIXEL: begin
        words = {1'b1, comp_r, 1'b1, comp_g, 1'b1, comp_b};
        wbits = lsw_pkg::BitsThreeWord;
      end
      default: begin
        words = '0;
        wbits = '0;
      end
    endcase
  end

  // leftover bits followed by the new words, left aligned
  assign stream = {pend_q, 33'd0} | ({words, 13'd0} >> pcnt_q);
  assign total  = {3'b000, pcnt_q} + wbits;
  assign nfull  = total[5:3];
  assign rem    = total[2:0];
  assign pad    = last_q & (rem != 3'd0);
  assign rest   = stream << {nfull, 3'b000};

  // leftover bits kept left aligned for the next item
  always_comb begin
    if (last_q) begin
      pend_d = '0;
      pcnt_d = '0;
    end else begin
      pend_d = rest[lsw_pkg::StreamW-1 -: lsw_pkg::PendW];
      pcnt_d = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= '0;
    end else if (pop) begin
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
    end
  end

  assign pack_valid_o  = in_valid_q;
  assign pack_o.stream = stream;
  assign pack_o.nbytes = nfull + {2'b00, pad};
  assign pack_o.last   = last_q;

endmodule

FILE: hw/rtl/lsw_emit.sv
`timescale 1ns / 1ps

module lsw_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pack_valid_i,
  output logic           pack_ready_o,
  input  lsw_pkg::pack_t pack_i,
  lsw_byte_if.source     out_o
);

  logic [lsw_pkg::StreamW-1:0] buf_q;
  logic [2:0]                  cnt_q;
  logic                        last_q;

  logic       ov_q;
  logic [7:0] ob_q;
  logic       re_q;
  logic       te_q;

  logic out_free;
  logic pop_byte;
  logic pack_ready;

  assign out_free   = ~ov_q | out_o.ready;
  assign pop_byte   = (cnt_q != 3'd0) & out_free;
  assign pack_ready = (cnt_q == 3'd0) | ((cnt_q == 3'd1) & out_free);
  assign pack_ready_o = pack_ready;

  // byte buffer, drained from the top one byte per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (pack_valid_i && pack_ready) begin
      cnt_q <= pack_i.nbytes;
    end else if (pop_byte) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pack_valid_i && pack_ready) begin
      buf_q  <= pack_i.stream;
      last_q <= pack_i.last;
    end else if (pop_byte) begin
      buf_q  <= {buf_q[lsw_pkg::StreamW-9:0], 8'd0};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (pop_byte) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_byte) begin
      ob_q <= buf_q[lsw_pkg::StreamW-1 -: 8];
      re_q <= (cnt_q == 3'd1);
      te_q <= (cnt_q == 3'd1) & last_q;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.out_byte     = ob_q;
  assign out_o.run_end      = re_q;
  assign out_o.transfer_end = te_q;

endmodule

FILE: hw/rtl/lcd_9bit_spi_word_packer_top.sv
`timescale 1ns / 1ps

// 9-bit 3-wire spi word packer for lcd controllers
// in_i takes commands, parameters and pixels; each adds one or three 9-bit
// words (flag bit then eight bits) to a continuous bit stream, msb first.
// out_o gives the stream as bytes, one per beat; run_end marks the last byte
// of an item and transfer_end the final byte of a transfer, zero-padded when
// its bits do not fill the byte. cfg_we_i/cfg_wdata_i write the colour format
// (0 rgb565, 1 eight-bit); the user is to keep to this: they are written only
// while the block is idle. The block itself does not enforce it.
// the block gives up to one output byte per cycle while out_o is ready; the
// byte buffer sends an item's bytes back to back and takes the next item with
// its last byte, so a pixel gives three or four bytes, five when it closes
// a transfer with padding, and a command or parameter one or two.
// an item that adds no whole byte still passes through the packer.
// reset clears the colour format to rgb565 and empties the leftover bits.
// when out_o stalls the output register holds its byte, the buffer fills
// and then in_i.ready falls; nothing is dropped.

module lcd_9bit_spi_word_packer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  lsw_item_if.sink   in_i,
  lsw_byte_if.source out_o
);

  logic           pack_valid;
  logic           pack_ready;
  lsw_pkg::pack_t pack;

  // packer: input register, colour expansion and bit alignment
  lsw_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_i),
    .pack_valid_o (pack_valid),
    .pack_ready_i (pack_ready),
    .pack_o       (pack)
  );

  // byte emitter: buffer and output register
  lsw_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pack_valid_i (pack_valid),
    .pack_ready_o (pack_ready),
    .pack_i       (pack),
    .out_o        (out_o)
  );

endmodule

FILE: dv/lsw_stream_checker.sv
`timescale 1ns / 1ps

module lsw_stream_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  lsw_item_if  item_i,
  lsw_byte_if  byte_i,
  output int   errors_o,
  output int   backlog_o
);

  typedef struct {
    logic [7:0] val;
    logic       run_end;
    logic       xfer_end;
  } stream_byte_t;

  // predictor state: colour format and leftover stream bits
  logic         fmt_8bit_q = 1'b0;
  logic [6:0]   left_bits_q = '0;
  logic [2:0]   left_cnt_q = '0;

  // scratch for one item being packed
  logic [63:0]  acc;
  int unsigned  acc_n;
  stream_byte_t item_bytes [5];
  int unsigned  item_n;

  stream_byte_t exp_bytes_q [$];
  int           n_fail = 0;
  int           backlog = 0;

  assign errors_o  = n_fail;
  assign backlog_o = backlog;

  function automatic logic [7:0] scale_comp(input logic [7:0] c, input int unsigned sh);
    logic [7:0] shifted;
    shifted = c << sh;
    return fmt_8bit_q ? c : shifted;
  endfunction

  task automatic emit_byte(input logic [7:0] b, input logic tend);
    if (item_n < 5) begin
      item_bytes[item_n] = '{b, 1'b0, tend};
      item_n++;
    end
  endtask

  // append one 9-bit word and peel off every whole byte
  task automatic add_word(input logic [8:0] w);
    acc = (acc << 9) | 64'(w);
    acc_n += 9;
    while (acc_n >= 8) begin
      acc_n -= 8;
      emit_byte(8'(acc >> acc_n), 1'b0);
      acc = acc & ((64'd1 << acc_n) - 64'd1);
    end
  endtask

  task automatic pack_item(input logic [1:0] kind, input logic [7:0] data,
                           input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic last);
    acc    = 64'(left_bits_q) & ((64'd1 << left_cnt_q) - 64'd1);
    acc_n  = left_cnt_q;
    item_n = 0;
    case (kind)
      lsw_pkg::KIND_CMD:   add_word({1'b0, data});
      lsw_pkg::KIND_PARAM: add_word({1'b1, data});
      lsw_pkg::KIND_PIXEL: begin
        add_word({1'b1, scale_comp(r, 3)});
        add_word({1'b1, scale_comp(g, 2)});
        add_word({1'b1, scale_comp(b, 3)});
      end
      default: ;
    endcase
    // flush: pad the partial byte, or mark the aligned last byte
    if (last) begin
      if (acc_n > 0) emit_byte(8'(acc << (8 - acc_n)), 1'b1);
      else if (item_n > 0) item_bytes[item_n-1].xfer_end = 1'b1;
      acc   = '0;
      acc_n = 0;
    end
    if (item_n > 0) item_bytes[item_n-1].run_end = 1'b1;
    for (int i = 0; i < item_n; i++) exp_bytes_q.push_back(item_bytes[i]);
    left_bits_q = acc[6:0];
    left_cnt_q  = acc_n[2:0];
  endtask

  task automatic note_fail(input string what, input stream_byte_t want);
    n_fail++;
    if (n_fail <= 10)
      $display("%0t %s: expected %02h run_end %0b transfer_end %0b, %s",
               $time, what, want.val, want.run_end, want.xfer_end,
               $sformatf("got %02h run_end %0b transfer_end %0b",
                         byte_i.out_byte, byte_i.run_end, byte_i.transfer_end));
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    stream_byte_t want;
    if (!rst_ni) begin
      fmt_8bit_q  = 1'b0;
      left_bits_q = '0;
      left_cnt_q  = '0;
      exp_bytes_q.delete();
      backlog     = 0;
    end else begin
      if (cfg_we_i) fmt_8bit_q = cfg_wdata_i;
      if (byte_i.valid && byte_i.ready) begin
        if (exp_bytes_q.size() == 0) begin
          note_fail("unexpected beat", '{8'h00, 1'b0, 1'b0});
        end else begin
          want = exp_bytes_q.pop_front();
          if (byte_i.out_byte !== want.val || byte_i.run_end !== want.run_end ||
              byte_i.transfer_end !== want.xfer_end)
            note_fail("mismatch", want);
        end
      end
      if (item_i.valid && item_i.ready)
        pack_item(item_i.kind, item_i.data_byte, item_i.red, item_i.green,
                  item_i.blue, item_i.last_item);
      backlog = exp_bytes_q.size();
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic       FmtRgb565  = 1'b0;
  localparam logic       FmtRgb888  = 1'b1;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_wdata;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned items_sent;
  int          errors;
  int          backlog;

  lsw_item_if item_if ();
  lsw_byte_if byte_if ();

  lcd_9bit_spi_word_packer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (item_if.sink),
    .out_o       (byte_if.source)
  );

  lsw_stream_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .byte_i      (byte_if),
    .errors_o    (errors),
    .backlog_o   (backlog)
  );

  // 50 MHz clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    byte_if.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // one item beat, with random idle cycles in front; called at a falling edge
  task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                           input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid = 1'b0;
      @(negedge clk_i);
    end
    item_if.valid     = 1'b1;
    item_if.kind      = kind;
    item_if.data_byte = data;
    item_if.red       = r;
    item_if.green     = g;
    item_if.blue      = b;
    item_if.last_item = last;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // command, some parameters, some pixels, last flag on the closing item
  task automatic send_transfer();
    int unsigned n_par;
    int unsigned n_pix;
    n_par = $urandom_range(3);
    n_pix = $urandom_range(6);
    send_item(lsw_pkg::KIND_CMD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              n_par + n_pix == 0);
    for (int i = 0; i < n_par; i++)
      send_item(lsw_pkg::KIND_PARAM, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                i == n_par - 1 && n_pix == 0);
    for (int i = 0; i < n_pix; i++)
      send_item(lsw_pkg::KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                i == n_pix - 1);
  endtask

  // mostly whole transfers, now and then a stray item of any kind
  task automatic random_phase(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0)
        send_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), $urandom_range(3) == 0);
      else
        send_transfer();
    end
  endtask

  // drain the output and let zero-byte items clear the pipeline
  task automatic settle();
    item_if.valid = 1'b0;
    while (backlog != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_format(input logic fmt);
    cfg_we    = 1'b1;
    cfg_wdata = fmt;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    item_if.valid     = 1'b0;
    item_if.kind      = lsw_pkg::KIND_CMD;
    item_if.data_byte = '0;
    item_if.red       = '0;
    item_if.green     = '0;
    item_if.blue      = '0;
    item_if.last_item = 1'b0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    items_sent        = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 23;
    recv_idle_pct = 85;

    // directed, rgb565: field extremes, overflow of shifted components
    set_format(FmtRgb565);
    send_item(lsw_pkg::KIND_CMD,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(lsw_pkg::KIND_PARAM, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_item(lsw_pkg::KIND_CMD,   8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(lsw_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    send_item(lsw_pkg::KIND_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_item(lsw_pkg::KIND_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
    send_item(lsw_pkg::KIND_PIXEL, 8'h00, 8'h1F, 8'h3F, 8'h1F, 1'b0);
    // unused kind flushing leftover bits, then with nothing to flush
    send_item(KindUnused, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(KindUnused, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    // eight commands fill nine whole bytes: byte-aligned close
    for (int i = 0; i < 8; i++)
      send_item(lsw_pkg::KIND_CMD, 8'hA5, 8'h00, 8'h00, 8'h00, i == 7);

    // directed, eight-bit components
    settle();
    set_format(FmtRgb888);
    send_item(lsw_pkg::KIND_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_item(lsw_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h80, 8'h01, 1'b1);
    send_item(lsw_pkg::KIND_PIXEL, 8'h00, 8'hA5, 8'h5A, 8'hC3, 1'b0);
    send_item(lsw_pkg::KIND_PARAM, 8'h3C, 8'h00, 8'h00, 8'h00, 1'b1);
    send_item(lsw_pkg::KIND_PIXEL, 8'h00, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);

    // random phases, each with its own idling, in alternating formats
    settle();
    set_format(FmtRgb565);
    random_phase(28);

    settle();
    send_idle_pct = 85;
    recv_idle_pct = 23;
    set_format(FmtRgb888);
    random_phase(28);

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_format(FmtRgb565);
    random_phase(28);

    settle();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
